// File: hw/rtl/dwg_pkg.sv
// dwg_pkg: shared types, register map and constants for the dds waveform generator
// used by every module under hw/rtl except dwg_ram; depends on nothing

package dwg_pkg;

    // fixed field widths of the bus and sample channels
    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 11;
    localparam int HALF_W  = 16;
    localparam int STEP_W  = 32;
    localparam int SAMPLE_W = 10;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_PHASE_WIDTH = 32;

    // control register offsets above the waveform table
    localparam int OFS_STEP_LO   = 0;
    localparam int OFS_STEP_HI   = 1;
    localparam int OFS_UPDATE    = 2;
    localparam int OFS_DAC_CTRL  = 3;
    localparam int OFS_PHASE_RST = 4;

    // sample sent while the dac output is disabled
    localparam logic [SAMPLE_W-1:0] MID_SCALE = SAMPLE_W'(1 << (SAMPLE_W - 1));

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // result kinds
    typedef enum logic {
        KIND_BUS = 1'b0,
        KIND_DAC = 1'b1
    } t_kind;

    // input transaction payload
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ADDR_W-1:0] addr;
        logic [HALF_W-1:0] wdata;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic                out_kind;
        logic [HALF_W-1:0]   read_data;
        logic [SAMPLE_W-1:0] dac_code;
    } t_out_item;

    // request issued to the result stage alongside the table read
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic              use_ram;
        logic              out_en;
        logic [HALF_W-1:0] reg_data;
    } t_issue;

endpackage

// File: hw/rtl/dds_waveform_generator_regs_unit.sv
// Register side of a dds waveform generator. It accepts one transaction per clock while
// not stalled: bus writes, bus reads and sample ticks, and returns a result for each read
// and tick through the waveform table read, registered alongside stage 1, and then the
// output register. Writes produce no result. The rate is one transaction per cycle while
// not stalled, set by the single read port of the waveform table, which serves either a
// bus read or a tick per cycle. The input stalls only while a result is waiting in the
// output register and the stage behind it is full. The waveform table has no reset and
// needs no clearing pass; an entry must be written before it is read or played.
// depends on dwg_pkg, dwg_ram, dwg_ctrl, dwg_out

module dds_waveform_generator_regs_unit #(
    parameter int TABLE_DEPTH = dwg_pkg::DEF_TABLE_DEPTH,
    parameter int PHASE_WIDTH = dwg_pkg::DEF_PHASE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dwg_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output dwg_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    localparam int TAB_AW = $clog2(TABLE_DEPTH);

    logic                         accept;
    dwg_pkg::t_issue              issue;
    logic                         ram_we, ram_re;
    logic [TAB_AW-1:0]            ram_waddr, ram_raddr;
    logic [dwg_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;

    // input transaction accepted
    assign accept = i_in_valid && !o_in_stall;

    // decode, registers and phase accumulator
    dwg_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_issue     (issue),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    // waveform table
    dwg_ram #(
        .WIDTH (dwg_pkg::SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result stage and output register
    dwg_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_ram_rdata (ram_rdata),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // input stalls only behind a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked output");

endmodule

// File: hw/rtl/dwg_ram.sv
// dwg_ram: generic simple dual port ram, one write and one registered read port
// standalone, no package dependency

module dwg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/dwg_ctrl.sv
// dwg_ctrl: request decode, control registers, phase accumulator and table access issue
// depends on dwg_pkg

module dwg_ctrl #(
    parameter int TABLE_DEPTH = dwg_pkg::DEF_TABLE_DEPTH,
    parameter int PHASE_WIDTH = dwg_pkg::DEF_PHASE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  dwg_pkg::t_in_item              i_item,
    output dwg_pkg::t_issue                o_issue,
    output logic                           o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_waddr,
    output logic [dwg_pkg::SAMPLE_W-1:0]   o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_raddr
);

    localparam int TAB_AW  = $clog2(TABLE_DEPTH);
    localparam int PROD_W  = PHASE_WIDTH + TAB_AW;

    logic [dwg_pkg::STEP_W-1:0] r_step_shadow, n_step_shadow;
    logic [dwg_pkg::STEP_W-1:0] r_step_active, n_step_active;
    logic [PHASE_WIDTH-1:0]     r_phase, n_phase;
    logic                       r_out_en, n_out_en;

    logic [31:0]             addr_ext;
    logic                    in_table;
    logic                    is_write, is_read, is_tick;
    logic                    hit_step_lo, hit_step_hi, hit_update, hit_dac_ctrl, hit_phase_rst;
    logic [PROD_W-1:0]       phase_prod;
    logic [TAB_AW-1:0]       phase_idx;
    logic [dwg_pkg::HALF_W-1:0] reg_rdata;

    // address decode
    assign addr_ext      = 32'(i_item.addr);
    assign in_table      = addr_ext < 32'(TABLE_DEPTH);
    assign hit_step_lo   = addr_ext == 32'(TABLE_DEPTH + dwg_pkg::OFS_STEP_LO);
    assign hit_step_hi   = addr_ext == 32'(TABLE_DEPTH + dwg_pkg::OFS_STEP_HI);
    assign hit_update    = addr_ext == 32'(TABLE_DEPTH + dwg_pkg::OFS_UPDATE);
    assign hit_dac_ctrl  = addr_ext == 32'(TABLE_DEPTH + dwg_pkg::OFS_DAC_CTRL);
    assign hit_phase_rst = addr_ext == 32'(TABLE_DEPTH + dwg_pkg::OFS_PHASE_RST);

    // request decode
    always_comb begin
        is_write = 1'b0;
        is_read  = 1'b0;
        is_tick  = 1'b0;
        unique case (i_item.req_type)
            dwg_pkg::REQ_WRITE: is_write = i_accept;
            dwg_pkg::REQ_READ:  is_read  = i_accept;
            dwg_pkg::REQ_TICK:  is_tick  = i_accept;
            default: ;
        endcase
    end

    // table index from the top phase bits, taken before the add
    assign phase_prod = PROD_W'(r_phase) * PROD_W'(TABLE_DEPTH);
    assign phase_idx  = phase_prod[PROD_W-1:PHASE_WIDTH];

    // control register readback
    always_comb begin
        reg_rdata = '0;
        if (hit_step_lo) begin
            reg_rdata = r_step_shadow[dwg_pkg::HALF_W-1:0];
        end else if (hit_step_hi) begin
            reg_rdata = r_step_shadow[dwg_pkg::STEP_W-1:dwg_pkg::HALF_W];
        end else if (hit_dac_ctrl) begin
            reg_rdata = dwg_pkg::HALF_W'(r_out_en);
        end
    end

    // table access
    assign o_ram_we    = is_write && in_table;
    assign o_ram_waddr = addr_ext[TAB_AW-1:0];
    assign o_ram_wdata = i_item.wdata[dwg_pkg::SAMPLE_W-1:0];
    assign o_ram_re    = is_tick || (is_read && in_table);
    assign o_ram_raddr = is_tick ? phase_idx : addr_ext[TAB_AW-1:0];

    // issue to the result stage
    always_comb begin
        o_issue.valid    = is_read || is_tick;
        o_issue.kind     = is_tick ? dwg_pkg::KIND_DAC : dwg_pkg::KIND_BUS;
        o_issue.use_ram  = is_read && in_table;
        o_issue.out_en   = r_out_en;
        o_issue.reg_data = reg_rdata;
    end

    // register next values
    always_comb begin
        n_step_shadow = r_step_shadow;
        n_step_active = r_step_active;
        n_phase       = r_phase;
        n_out_en      = r_out_en;
        if (is_write) begin
            if (hit_step_lo) begin
                n_step_shadow[dwg_pkg::HALF_W-1:0] = i_item.wdata;
            end
            if (hit_step_hi) begin
                n_step_shadow[dwg_pkg::STEP_W-1:dwg_pkg::HALF_W] = i_item.wdata;
            end
            if (hit_update) begin
                n_step_active = r_step_shadow;
            end
            if (hit_dac_ctrl) begin
                n_out_en = i_item.wdata[0];
            end
            if (hit_phase_rst) begin
                n_phase = '0;
            end
        end
        if (is_tick) begin
            n_phase = r_phase + PHASE_WIDTH'(r_step_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_shadow <= '0;
            r_step_active <= '0;
            r_phase       <= '0;
            r_out_en      <= 1'b0;
        end else begin
            r_step_shadow <= n_step_shadow;
            r_step_active <= n_step_active;
            r_phase       <= n_phase;
            r_out_en      <= n_out_en;
        end
    end

    // phase reset strobe clears the accumulator
    a_phase_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write && hit_phase_rst |=> r_phase == '0)
        else $error("phase not cleared by reset strobe");

    // update strobe copies the shadow step
    a_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write && hit_update |=> r_step_active == $past(r_step_shadow))
        else $error("active step not loaded from shadow");

endmodule

// File: hw/rtl/dwg_out.sv
// dwg_out: result stage aligned with the table read, plus output register and stall logic
// depends on dwg_pkg

module dwg_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dwg_pkg::t_issue              i_issue,
    input  logic [dwg_pkg::SAMPLE_W-1:0] i_ram_rdata,
    input  logic                         i_out_stall,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output dwg_pkg::t_out_item           o_out_data
);

    dwg_pkg::t_issue    r_s1, n_s1;
    dwg_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;
    logic               out_free;

    // output register can take a new result
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1.valid && !out_free;

    // stage 1 holds while full and the output is blocked; the table read data holds with it
    assign n_s1 = (out_free || !r_s1.valid) ? i_issue : r_s1;

    // result formation
    always_comb begin
        n_out = '0;
        n_out.out_kind = r_s1.kind;
        if (r_s1.kind == dwg_pkg::KIND_DAC) begin
            n_out.dac_code = r_s1.out_en ? i_ram_rdata : dwg_pkg::MID_SCALE;
        end else if (r_s1.use_ram) begin
            n_out.read_data = dwg_pkg::HALF_W'(i_ram_rdata);
        end else begin
            n_out.read_data = r_s1.reg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            if (out_free) begin
                r_out_valid <= r_s1.valid;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1.valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // bus results carry no sample
    a_bus_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_kind == dwg_pkg::KIND_BUS |-> o_out_data.dac_code == '0)
        else $error("bus result with nonzero dac code");

    // sample results carry no readback
    a_dac_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_kind == dwg_pkg::KIND_DAC |-> o_out_data.read_data == '0)
        else $error("sample result with nonzero read data");

endmodule

// File: tb/dds_sample_checker.sv
`timescale 1ns / 100ps
// dds_sample_checker: watches the request and result channels of the dds waveform generator,
// keeps its own table, step and phase state and compares every result transaction
// depends on dwg_pkg

module dds_sample_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dwg_pkg::t_in_item  i_in_data,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  dwg_pkg::t_out_item i_out_data,
    input  logic               i_out_stall,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    localparam int TBL_DEPTH     = dwg_pkg::DEF_TABLE_DEPTH;
    localparam int PH_W          = dwg_pkg::DEF_PHASE_WIDTH;
    localparam int IDX_W         = $clog2(TBL_DEPTH);
    localparam int HALF_W        = dwg_pkg::HALF_W;
    localparam int STEP_W        = dwg_pkg::STEP_W;
    localparam int SAMPLE_W      = dwg_pkg::SAMPLE_W;
    localparam int ADDR_STEP_LO  = TBL_DEPTH + dwg_pkg::OFS_STEP_LO;
    localparam int ADDR_STEP_HI  = TBL_DEPTH + dwg_pkg::OFS_STEP_HI;
    localparam int ADDR_UPDATE   = TBL_DEPTH + dwg_pkg::OFS_UPDATE;
    localparam int ADDR_DAC_CTRL = TBL_DEPTH + dwg_pkg::OFS_DAC_CTRL;
    localparam int ADDR_PH_RST   = TBL_DEPTH + dwg_pkg::OFS_PHASE_RST;

    // local copy of the generator state
    logic [SAMPLE_W-1:0] wave_copy [TBL_DEPTH];
    logic [STEP_W-1:0]   step_shadow;
    logic [STEP_W-1:0]   step_live;
    logic [PH_W-1:0]     phase;
    logic                dac_on;

    // results still owed by the block, oldest first
    dwg_pkg::t_out_item awaited[$];

    // update the state for one request and queue the result it owes
    task automatic apply_request(input dwg_pkg::t_in_item req);
        dwg_pkg::t_out_item res;
        int unsigned        a;
        a   = req.addr;
        res = '0;
        case (req.req_type)
            dwg_pkg::REQ_WRITE: begin
                if (a < TBL_DEPTH)
                    wave_copy[a] = req.wdata[SAMPLE_W-1:0];
                else if (a == ADDR_STEP_LO)
                    step_shadow[HALF_W-1:0] = req.wdata;
                else if (a == ADDR_STEP_HI)
                    step_shadow[STEP_W-1:HALF_W] = req.wdata;
                else if (a == ADDR_UPDATE)
                    step_live = step_shadow;
                else if (a == ADDR_DAC_CTRL)
                    dac_on = req.wdata[0];
                else if (a == ADDR_PH_RST)
                    phase = '0;
            end
            dwg_pkg::REQ_READ: begin
                res.out_kind = dwg_pkg::KIND_BUS;
                if (a < TBL_DEPTH)
                    res.read_data = HALF_W'(wave_copy[a]);
                else if (a == ADDR_STEP_LO)
                    res.read_data = step_shadow[HALF_W-1:0];
                else if (a == ADDR_STEP_HI)
                    res.read_data = step_shadow[STEP_W-1:HALF_W];
                else if (a == ADDR_DAC_CTRL)
                    res.read_data = HALF_W'(dac_on);
                awaited.push_back(res);
            end
            dwg_pkg::REQ_TICK: begin
                // sample comes from the phase before the add
                res.out_kind = dwg_pkg::KIND_DAC;
                res.dac_code = dac_on ? wave_copy[phase[PH_W-1 -: IDX_W]] : dwg_pkg::MID_SCALE;
                phase        = phase + PH_W'(step_live);
                awaited.push_back(res);
            end
            default: ;
        endcase
    endtask

    // compare one result transaction with the oldest one owed
    task automatic compare_result(input dwg_pkg::t_out_item got);
        dwg_pkg::t_out_item want;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result kind %0h read_data %0h dac_code %0h",
                     $time, got.out_kind, got.read_data, got.dac_code);
            o_mismatches++;
        end else begin
            want = awaited.pop_front();
            if (got.out_kind !== want.out_kind) begin
                $display("%0t: out_kind expected %0h got %0h",
                         $time, want.out_kind, got.out_kind);
                o_mismatches++;
            end
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data expected %0h got %0h",
                         $time, want.read_data, got.read_data);
                o_mismatches++;
            end
            if (got.dac_code !== want.dac_code) begin
                $display("%0t: dac_code expected %0h got %0h",
                         $time, want.dac_code, got.dac_code);
                o_mismatches++;
            end
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_shadow  = '0;
            step_live    = '0;
            phase        = '0;
            dac_on       = 1'b0;
            o_mismatches = 0;
            awaited.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                compare_result(i_out_data);
            if (i_in_valid && !i_in_stall)
                apply_request(i_in_data);
        end
        o_outstanding = awaited.size();
    end

endmodule

// File: tb/dds_waveform_generator_regs_unit_tb.sv
`timescale 1ns / 100ps
// dds_waveform_generator_regs_unit_tb: drives bus writes, bus reads and sample ticks into the
// dds waveform generator with random idling on both sides and reports the verdict
// depends on dwg_pkg, dds_sample_checker and the dds_waveform_generator_regs_unit rtl

module dds_waveform_generator_regs_unit_tb;

    localparam int REQ_W       = dwg_pkg::REQ_W;
    localparam int ADDR_W      = dwg_pkg::ADDR_W;
    localparam int HALF_W      = dwg_pkg::HALF_W;
    localparam int TBL_DEPTH   = dwg_pkg::DEF_TABLE_DEPTH;
    localparam int A_STEP_LO   = TBL_DEPTH + dwg_pkg::OFS_STEP_LO;
    localparam int A_STEP_HI   = TBL_DEPTH + dwg_pkg::OFS_STEP_HI;
    localparam int A_UPDATE    = TBL_DEPTH + dwg_pkg::OFS_UPDATE;
    localparam int A_DAC_CTRL  = TBL_DEPTH + dwg_pkg::OFS_DAC_CTRL;
    localparam int A_PHASE_RST = TBL_DEPTH + dwg_pkg::OFS_PHASE_RST;
    localparam int A_LAST      = (1 << ADDR_W) - 1;
    localparam int HALF_MAX    = (1 << HALF_W) - 1;

    // request code the block does not know
    localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;

    localparam int N_RANDOM     = 650;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_CYCLES  = 40;
    localparam int RUN_LIMIT_NS = 5000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    dwg_pkg::t_in_item  i_in_data;
    logic               o_in_stall;
    logic               o_out_valid;
    dwg_pkg::t_out_item o_out_data;
    logic               i_out_stall;

    int mismatches;
    int outstanding;
    bit quiet;
    bit rx_hold_req;

    dds_waveform_generator_regs_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    dds_sample_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_out_data    (o_out_data),
        .i_out_stall   (i_out_stall),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the run hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("[dds_waveform_generator_regs_unit] ERROR");
        $finish;
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin : rx_side
        int hold_left;
        int burst_left;
        bit burst_stall;
        hold_left   = 0;
        burst_left  = 0;
        burst_stall = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    burst_stall = ($urandom_range(0, 3) == 0);
                    burst_left  = $urandom_range(1, 6);
                end
                burst_left--;
                i_out_stall <= burst_stall;
            end
        end
    end

    function automatic dwg_pkg::t_in_item make_request(input logic [REQ_W-1:0] kind,
                                                       input int unsigned addr,
                                                       input int unsigned data);
        dwg_pkg::t_in_item req;
        req.req_type = kind;
        req.addr     = ADDR_W'(addr);
        req.wdata    = HALF_W'(data);
        return req;
    endfunction

    // offer one transaction, maybe after an idle burst, and wait for acceptance
    task automatic send_request(input dwg_pkg::t_in_item req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold the request side idle until every owed result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // one random operation; a step update is a lo, hi, update sequence
    task automatic send_random_op(output int sent);
        int          pick;
        int unsigned a;
        logic [15:0] d;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        sent = 1;
        if (pick < 45) begin
            send_request(make_request(dwg_pkg::REQ_TICK, $urandom_range(0, A_LAST),
                                      $urandom_range(0, HALF_MAX)));
        end else if (pick < 63) begin
            case ($urandom_range(0, 9))
                0, 1:    a = $urandom_range(A_STEP_LO, A_PHASE_RST);
                2:       a = $urandom_range(0, A_LAST);
                default: a = $urandom_range(0, TBL_DEPTH - 1);
            endcase
            send_request(make_request(dwg_pkg::REQ_READ, a, $urandom_range(0, HALF_MAX)));
        end else if (pick < 76) begin
            send_request(make_request(dwg_pkg::REQ_WRITE, $urandom_range(0, TBL_DEPTH - 1),
                                      $urandom_range(0, HALF_MAX)));
        end else if (pick < 84) begin
            // small steps crawl through neighboring table entries
            step = $urandom;
            if ($urandom_range(0, 1) == 1)
                step = step >> $urandom_range(8, 28);
            send_request(make_request(dwg_pkg::REQ_WRITE, A_STEP_LO, step[15:0]));
            send_request(make_request(dwg_pkg::REQ_WRITE, A_STEP_HI, step[31:16]));
            send_request(make_request(dwg_pkg::REQ_WRITE, A_UPDATE,
                                      $urandom_range(0, HALF_MAX)));
            sent = 3;
        end else if (pick < 90) begin
            a = ($urandom_range(0, 1) == 1) ? A_STEP_HI : A_STEP_LO;
            send_request(make_request(dwg_pkg::REQ_WRITE, a, $urandom_range(0, HALF_MAX)));
        end else if (pick < 93) begin
            send_request(make_request(dwg_pkg::REQ_WRITE, A_UPDATE,
                                      $urandom_range(0, HALF_MAX)));
        end else if (pick < 96) begin
            d    = 16'($urandom);
            d[0] = ($urandom_range(0, 3) != 0);
            send_request(make_request(dwg_pkg::REQ_WRITE, A_DAC_CTRL, d));
        end else if (pick < 97) begin
            send_request(make_request(dwg_pkg::REQ_WRITE, A_PHASE_RST,
                                      $urandom_range(0, HALF_MAX)));
        end else if (pick < 99) begin
            // unmapped space above the control registers
            a = $urandom_range(A_PHASE_RST + 1, A_LAST);
            if ($urandom_range(0, 1) == 1)
                send_request(make_request(dwg_pkg::REQ_WRITE, a,
                                          $urandom_range(0, HALF_MAX)));
            else
                send_request(make_request(dwg_pkg::REQ_READ, a,
                                          $urandom_range(0, HALF_MAX)));
        end else begin
            send_request(make_request(REQ_BAD, $urandom_range(0, A_LAST),
                                      $urandom_range(0, HALF_MAX)));
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int sent;
        int total;
        int op_no;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        quiet       = 1'b0;
        rx_hold_req = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, shadow versus active step, output disabled
        send_request(make_request(dwg_pkg::REQ_READ, A_STEP_LO, 0));
        send_request(make_request(dwg_pkg::REQ_READ, A_DAC_CTRL, 0));
        send_request(make_request(dwg_pkg::REQ_READ, A_UPDATE, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));
        send_request(make_request(dwg_pkg::REQ_WRITE, A_STEP_LO, HALF_MAX));
        send_request(make_request(dwg_pkg::REQ_WRITE, A_STEP_HI, HALF_MAX));
        send_request(make_request(dwg_pkg::REQ_READ, A_STEP_LO, 0));
        send_request(make_request(dwg_pkg::REQ_READ, A_STEP_HI, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, A_LAST, HALF_MAX));
        send_request(make_request(dwg_pkg::REQ_WRITE, A_UPDATE, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));
        // unmapped space, strobe readback, unknown request
        send_request(make_request(dwg_pkg::REQ_WRITE, A_LAST, HALF_MAX));
        send_request(make_request(dwg_pkg::REQ_READ, A_LAST, HALF_MAX));
        send_request(make_request(dwg_pkg::REQ_READ, A_PHASE_RST, 0));
        send_request(make_request(REQ_BAD, 0, HALF_MAX));
        // only bit 0 of dac control counts
        send_request(make_request(dwg_pkg::REQ_WRITE, A_DAC_CTRL, 16'hFFFE));
        send_request(make_request(dwg_pkg::REQ_READ, A_DAC_CTRL, 0));
        send_request(make_request(dwg_pkg::REQ_WRITE, A_PHASE_RST, 0));

        // load the whole waveform table before any entry is read or played
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (i == 0)
                send_request(make_request(dwg_pkg::REQ_WRITE, i, HALF_MAX));
            else if (i == TBL_DEPTH - 1)
                send_request(make_request(dwg_pkg::REQ_WRITE, i, 16'hFC00));
            else
                send_request(make_request(dwg_pkg::REQ_WRITE, i,
                                          $urandom_range(0, HALF_MAX)));
        end

        // table ends, enable, full-scale step wraps the phase
        send_request(make_request(dwg_pkg::REQ_READ, 0, 0));
        send_request(make_request(dwg_pkg::REQ_READ, TBL_DEPTH - 1, 0));
        send_request(make_request(dwg_pkg::REQ_WRITE, A_DAC_CTRL, 16'h0001));
        send_request(make_request(dwg_pkg::REQ_READ, A_DAC_CTRL, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));
        send_request(make_request(dwg_pkg::REQ_TICK, 0, 0));

        // random traffic with one long result hold-off and two full drains
        total = 0;
        op_no = 0;
        while (total < N_RANDOM) begin
            if (op_no == 100)
                rx_hold_req = 1'b1;
            if (op_no == 200 || op_no == 400)
                wait_for_results();
            if (total >= N_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            send_random_op(sent);
            total += sent;
            op_no++;
        end

        // drain and let the pipeline settle
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[dds_waveform_generator_regs_unit] OK");
        end else begin
            $display("[dds_waveform_generator_regs_unit] ERROR");
        end
        $finish;
    end

endmodule
